### rtl/ntpf_pkg.sv
// ---------------------------------------------------------------------------
// ntpf_pkg
// Shared types and protocol constants for the NTP/UDP frame classifier.
// ---------------------------------------------------------------------------
package ntpf_pkg;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] PORT_NTP      = 16'd123;
    localparam logic [3:0]  IP_VERSION4   = 4'd4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;

    // Fixed header offsets (bytes from start of frame)
    localparam logic [7:0]  OFF_ETYPE_HI  = 8'd12;
    localparam logic [7:0]  OFF_ETYPE_LO  = 8'd13;
    localparam logic [7:0]  OFF_INNER_HI  = 8'd16;
    localparam logic [7:0]  OFF_INNER_LO  = 8'd17;
    localparam logic [7:0]  IP_OFF_PLAIN  = 8'd14;
    localparam logic [7:0]  IP_OFF_VLAN   = 8'd18;
    localparam logic [7:0]  BYTE_CNT_MAX  = 8'd255;

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } stage_item_t;

    // Per-frame decision from the parser
    typedef struct packed {
        logic valid;
        logic is_match;
    } verdict_t;

endpackage

### rtl/ntpf_in_stage.sv
// ---------------------------------------------------------------------------
// ntpf_in_stage
// Input register: captures one byte request per cycle from the stream while s_ready is high.
// ---------------------------------------------------------------------------
module ntpf_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    input  logic [7:0]           s_data,
    input  logic                 s_last,
    input  logic                 advance,   // downstream consumes held byte
    output logic                 s_ready,
    output ntpf_pkg::stage_item_t item
);

    logic       valid_reg;
    logic       last_reg;
    logic [7:0] data_reg;

    assign s_ready = !valid_reg || advance;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            last_reg <= s_last;
            data_reg <= s_data;
        end
    end

    assign item.valid = valid_reg;
    assign item.last  = last_reg;
    assign item.data  = data_reg;

endmodule

### rtl/ntpf_hdr_parser.sv
// ---------------------------------------------------------------------------
// ntpf_hdr_parser
// Byte position tracking, header field capture and end-of-frame check.
// ---------------------------------------------------------------------------
module ntpf_hdr_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,   // consume item this cycle
    input  ntpf_pkg::stage_item_t item,
    output ntpf_pkg::verdict_t    verdict
);

    logic [7:0]  byte_count_reg;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic        vlan_seen_reg, vlan_seen_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic [12:0] fragment_reg, fragment_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic [7:0]  byte_count_next;

    logic [7:0]  pos;
    logic [7:0]  b;
    logic [7:0]  ip_off;
    logic [7:0]  hdr_len;
    logic [7:0]  port_pos;
    logic [8:0]  frame_len;
    logic        match;

    assign pos = byte_count_reg;
    assign b   = item.data;

    // Field capture at fixed and derived offsets
    always_comb
    begin
        ether_kind_next  = ether_kind_reg;
        vlan_seen_next   = vlan_seen_reg;
        version_ihl_next = version_ihl_reg;
        ip_protocol_next = ip_protocol_reg;
        fragment_next    = fragment_reg;
        dest_port_next   = dest_port_reg;

        if (pos == ntpf_pkg::OFF_ETYPE_HI)
        begin
            ether_kind_next = {b, 8'h00};
        end
        else if (pos == ntpf_pkg::OFF_ETYPE_LO)
        begin
            ether_kind_next = {ether_kind_reg[15:8], b};
            vlan_seen_next  = ({ether_kind_reg[15:8], b} == ntpf_pkg::ETH_TYPE_VLAN);
        end

        ip_off = vlan_seen_next ? ntpf_pkg::IP_OFF_VLAN : ntpf_pkg::IP_OFF_PLAIN;

        // inner ethertype behind a single VLAN tag
        if (vlan_seen_next)
        begin
            if (pos == ntpf_pkg::OFF_INNER_HI)
            begin
                ether_kind_next = {b, 8'h00};
            end
            else if (pos == ntpf_pkg::OFF_INNER_LO)
            begin
                ether_kind_next = {ether_kind_reg[15:8], b};
            end
        end

        if (pos == ip_off)
        begin
            version_ihl_next = b;
        end
        if (pos == ip_off + 8'd6)
        begin
            fragment_next = {b[4:0], 8'h00};
        end
        if (pos == ip_off + 8'd7)
        begin
            fragment_next = fragment_reg | {5'b0, b};
        end
        if (pos == ip_off + 8'd9)
        begin
            ip_protocol_next = b;
        end

        hdr_len  = {2'b00, version_ihl_next[3:0], 2'b00};
        port_pos = ip_off + hdr_len + 8'd2;
        if (pos == port_pos)
        begin
            dest_port_next = {b, 8'h00};
        end
        if (pos == port_pos + 8'd1)
        begin
            dest_port_next = {dest_port_reg[15:8], b};
        end
    end

    assign byte_count_next = (byte_count_reg != ntpf_pkg::BYTE_CNT_MAX) ?
                             byte_count_reg + 8'd1 : byte_count_reg;

    // Frame decision on the last byte
    assign frame_len = {1'b0, pos} + 9'd1;

    assign match = (frame_len >= 9'd14) &&
                   (ether_kind_next == ntpf_pkg::ETH_TYPE_IPV4) &&
                   (frame_len >= {1'b0, ip_off} + 9'd20) &&
                   (version_ihl_next[7:4] == ntpf_pkg::IP_VERSION4) &&
                   (version_ihl_next[3:0] >= ntpf_pkg::IHL_MIN) &&
                   (frame_len >= {1'b0, ip_off} + {1'b0, hdr_len} + 9'd8) &&
                   (ip_protocol_next == ntpf_pkg::PROTO_UDP) &&
                   (fragment_next == 13'd0) &&
                   (dest_port_next == ntpf_pkg::PORT_NTP);

    assign verdict.valid    = enable && item.last;
    assign verdict.is_match = match;

    // Frame state: cleared after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            ether_kind_reg  <= '0;
            vlan_seen_reg   <= 1'b0;
            version_ihl_reg <= '0;
            ip_protocol_reg <= '0;
            fragment_reg    <= '0;
            dest_port_reg   <= '0;
        end
        else if (enable)
        begin
            if (item.last)
            begin
                byte_count_reg  <= '0;
                ether_kind_reg  <= '0;
                vlan_seen_reg   <= 1'b0;
                version_ihl_reg <= '0;
                ip_protocol_reg <= '0;
                fragment_reg    <= '0;
                dest_port_reg   <= '0;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                ether_kind_reg  <= ether_kind_next;
                vlan_seen_reg   <= vlan_seen_next;
                version_ihl_reg <= version_ihl_next;
                ip_protocol_reg <= ip_protocol_next;
                fragment_reg    <= fragment_next;
                dest_port_reg   <= dest_port_next;
            end
        end
    end

    // A match needs at least Ethernet + minimal IPv4 + UDP headers (42 bytes)
    a_match_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.is_match) |-> (pos >= 8'd41))
        else $error("match reported on a frame shorter than 42 bytes");

    // Position restarts after a last byte
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (enable && item.last) |=> (byte_count_reg == 8'd0))
        else $error("byte counter not cleared after end of frame");

endmodule

### rtl/ntp_udp_frame_classifier.sv
// ---------------------------------------------------------------------------
// ntp_udp_frame_classifier
// Flags Ethernet frames carrying IPv4 UDP with fragment offset zero to port 123.
// ---------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on the s_axis channel, one byte per request in wire
//   order, with s_axis_tlast on the final byte. For each frame one result
//   request leaves on m_axis: m_axis_tdata[0] is 1 when the frame is IPv4
//   (optionally behind one VLAN tag), version 4, IHL >= 5, UDP, fragment
//   offset zero, destination port 123, and long enough for all headers.
//   Bytes other than the last one produce no output.
//   Throughput: one byte per cycle while s_axis_tready is high; the parser
//   updates its header state for each byte it consumes.
//   After the last byte is accepted it sits in the input register; the
//   parser's combinational verdict is then loaded into the result
//   register, which drives m_axis_tvalid.
//   Reset: rst_n clears the byte counter, captured header fields and both
//   valid bits; the next byte is taken as the start of a frame.
//   Stall: while a result waits on m_axis, non-final bytes keep flowing;
//   a following last byte is held in the input register, with
//   s_axis_tready low, until the result is taken.
// ---------------------------------------------------------------------------
module ntp_udp_frame_classifier
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_match, [7:1] zero
);

    ntpf_pkg::stage_item_t item;
    ntpf_pkg::verdict_t    verdict;
    logic                  advance;
    logic                  out_valid_reg;
    logic                  out_match_reg;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_axis_tready;
    // Only a last byte needs room in the result register
    assign advance  = !item.last || out_free;

    ntpf_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_data  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .advance (advance),
        .s_ready (s_axis_tready),
        .item    (item)
    );

    ntpf_hdr_parser u_hdr_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (item.valid && advance),
        .item    (item),
        .verdict (verdict)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= verdict.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && verdict.valid)
        begin
            out_match_reg <= verdict.is_match;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_match_reg};

    // Backpressure comes only from a full result register
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A held last byte is not dropped while the result is stalled
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.last && out_valid_reg && !m_axis_tready) |=> item.valid)
        else $error("last byte lost during output stall");

    // Output only ever refills from a parsed last byte
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tready && !verdict.valid) |=> !out_valid_reg)
        else $error("result appeared without a last byte");

endmodule
